// ===== rtl/nearest_centroid_confusion_counter_defines.svh =====
// assertion macros used by the confusion counter top level
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef NEAREST_CENTROID_CONFUSION_COUNTER_DEFINES_SVH
`define NEAREST_CENTROID_CONFUSION_COUNTER_DEFINES_SVH

// same-cycle implication, off while in reset
`define NCC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define NCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ncc_pkg.sv =====
// shared types and constants for the nearest centre confusion counter
// no dependencies
`timescale 1ns / 1ps

package ncc_pkg;

  localparam int unsigned NumCenters   = 6;
  localparam int unsigned SampleBits   = 12;
  localparam int unsigned CountBits    = 16;
  localparam int unsigned IdxBits      = 3;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned NumAxes      = 3;
  localparam int unsigned CenterBits   = NumAxes * SampleBits;
  localparam int unsigned NumCells     = NumCenters * NumCenters;
  localparam int unsigned CellAddrBits = $clog2(NumCells);
  localparam int unsigned SqBits       = 2 * SampleBits;
  localparam int unsigned DistBits     = SqBits + 2;
  localparam int unsigned QueueDepth   = 8;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned CreditBits   = $clog2(QueueDepth + 1);

  typedef logic [CenterBits-1:0] center_t;
  typedef logic [IdxBits-1:0]    idx_t;

  // reset centres, z in the top twelve bits and x in the bottom
  localparam center_t CenterReset [NumCenters] = '{
    36'd25171969850, 36'd25171969200, 36'd25173403100,
    36'd25170740700, 36'd31043995100, 36'd20138804700
  };

  typedef enum logic [1:0] {
    REQ_CLASSIFY = 2'd0,
    REQ_READ     = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_NOP      = 2'd3
  } req_e;

  // one classified request on its way to the matrix
  typedef struct packed {
    req_e req;
    idx_t winner;
    idx_t row;
    idx_t col;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/ncc_front.sv =====
// front end: centre registers and the pipelined nearest centre search
// depends on ncc_pkg
`timescale 1ns / 1ps

module ncc_front import ncc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CenterBits-1:0] cfg_wdata_i,
  input  logic                  accept_i,
  input  logic [1:0]            req_type_i,
  input  logic [SampleBits-1:0] sample_x_i,
  input  logic [SampleBits-1:0] sample_y_i,
  input  logic [SampleBits-1:0] sample_z_i,
  input  logic [IdxBits-1:0]    true_class_i,
  input  logic [IdxBits-1:0]    read_row_i,
  input  logic [IdxBits-1:0]    read_column_i,
  output logic                  job_valid_o,
  output job_t                  job_o
);

  localparam int unsigned NumPairs = (NumCenters + 1) / 2;

  typedef struct packed {
    req_e req;
    idx_t tc;
    idx_t rr;
    idx_t rc;
  } carry_t;

  center_t               center_q [NumCenters];
  logic                  s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  carry_t                s1_carry_q, s2_carry_q, s3_carry_q, s4_carry_q;
  logic [SampleBits-1:0] s1_smp_q [NumAxes];
  logic [SampleBits-1:0] adiff [NumCenters][NumAxes];
  logic [SqBits-1:0]     sq_d [NumCenters][NumAxes];
  logic [SqBits-1:0]     sq_q [NumCenters][NumAxes];
  logic [DistBits-1:0]   dist_d [NumCenters];
  logic [DistBits-1:0]   dist_q [NumCenters];
  logic [DistBits-1:0]   pair_dist_d [NumPairs];
  logic [DistBits-1:0]   pair_dist_q [NumPairs];
  idx_t                  pair_idx_d [NumPairs];
  idx_t                  pair_idx_q [NumPairs];
  logic [DistBits-1:0]   best_dist;
  idx_t                  best_idx;
  job_t                  s5_job_d, s5_job_q;

  // centre registers, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCenters; c++) begin
        center_q[c] <= CenterReset[c];
      end
    end else begin
      for (int c = 0; c < NumCenters; c++) begin
        if (cfg_valid_i && cfg_index_i == CfgIdxBits'(c)) begin
          center_q[c] <= cfg_wdata_i;
        end
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  // stage 1: input capture
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_carry_q.req <= req_e'(req_type_i);
      s1_carry_q.tc  <= true_class_i;
      s1_carry_q.rr  <= read_row_i;
      s1_carry_q.rc  <= read_column_i;
      s1_smp_q[0]    <= sample_x_i;
      s1_smp_q[1]    <= sample_y_i;
      s1_smp_q[2]    <= sample_z_i;
    end
  end

  // stage 2: per axis absolute difference and square
  always_comb begin
    for (int c = 0; c < NumCenters; c++) begin
      for (int a = 0; a < NumAxes; a++) begin
        adiff[c][a] = (center_q[c][a*SampleBits +: SampleBits] > s1_smp_q[a])
                    ? center_q[c][a*SampleBits +: SampleBits] - s1_smp_q[a]
                    : s1_smp_q[a] - center_q[c][a*SampleBits +: SampleBits];
        sq_d[c][a]  = {{SampleBits{1'b0}}, adiff[c][a]}
                    * {{SampleBits{1'b0}}, adiff[c][a]};
      end
    end
  end

  // stage 3: squared distance per centre
  always_comb begin
    for (int c = 0; c < NumCenters; c++) begin
      dist_d[c] = DistBits'(sq_q[c][0]) + DistBits'(sq_q[c][1]) + DistBits'(sq_q[c][2]);
    end
  end

  // stage 4: pairwise minimum, the lower index keeps a tie
  always_comb begin
    for (int p = 0; p < NumPairs; p++) begin
      pair_dist_d[p] = dist_q[2*p];
      pair_idx_d[p]  = IdxBits'(2*p);
      if ((2*p + 1) < NumCenters) begin
        if (dist_q[2*p+1] < dist_q[2*p]) begin
          pair_dist_d[p] = dist_q[2*p+1];
          pair_idx_d[p]  = IdxBits'(2*p + 1);
        end
      end
    end
  end

  // stage 5: final pick over the pair winners and job formation
  always_comb begin
    best_dist = pair_dist_q[0];
    best_idx  = pair_idx_q[0];
    for (int p = 1; p < NumPairs; p++) begin
      if (pair_dist_q[p] < best_dist) begin
        best_dist = pair_dist_q[p];
        best_idx  = pair_idx_q[p];
      end
    end
    s5_job_d.req = s4_carry_q.req;
    case (s4_carry_q.req)
      REQ_CLASSIFY: begin
        s5_job_d.winner = best_idx;
        s5_job_d.row    = s4_carry_q.tc;
        s5_job_d.col    = best_idx;
      end
      REQ_READ: begin
        s5_job_d.winner = '0;
        s5_job_d.row    = s4_carry_q.rr;
        s5_job_d.col    = s4_carry_q.rc;
      end
      default: begin
        s5_job_d.winner = '0;
        s5_job_d.row    = '0;
        s5_job_d.col    = '0;
      end
    endcase
  end

  // pipeline payload registers
  always_ff @(posedge clk_i) begin
    sq_q        <= sq_d;
    s2_carry_q  <= s1_carry_q;
    dist_q      <= dist_d;
    s3_carry_q  <= s2_carry_q;
    pair_dist_q <= pair_dist_d;
    pair_idx_q  <= pair_idx_d;
    s4_carry_q  <= s3_carry_q;
    s5_job_q    <= s5_job_d;
  end

  assign job_valid_o = s5_valid_q;
  assign job_o       = s5_job_q;

endmodule

// ===== rtl/ncc_queue.sv =====
// small first-in first-out queue of classified jobs between front and back
// depends on ncc_pkg
`timescale 1ns / 1ps

module ncc_queue import ncc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      push_data_i,
  input  logic      pop_i,
  output job_t      data_o,
  output q_status_t status_o
);

  job_t                    slot_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CreditBits-1:0]   count_q;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign data_o         = slot_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CreditBits'(QueueDepth));

endmodule

// ===== rtl/ncc_back.sv =====
// back end: confusion matrix memory, saturating update and result register
// depends on ncc_pkg
`timescale 1ns / 1ps

module ncc_back import ncc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  job_t                 job_i,
  output logic                 job_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IdxBits-1:0]   winner_o,
  output logic [CountBits-1:0] cell_count_o
);

  logic [CountBits-1:0]    cell_mem [NumCells];
  logic [NumCells-1:0]     cell_valid_q;
  logic [CountBits-1:0]    rdata_q;
  logic                    rvalid_q;

  logic                    in_range;
  logic [CellAddrBits-1:0] addr;
  logic                    pop;

  logic                    r_valid_q;
  job_t                    r_job_q;
  logic [CellAddrBits-1:0] r_addr_q;
  logic                    r_inrange_q;
  logic                    r_fwd_q;
  logic [CountBits-1:0]    r_fwd_data_q;
  logic                    r_cleared_q;
  logic                    r_fire;
  logic [CountBits-1:0]    cur;
  logic [CountBits-1:0]    inc;
  logic                    w_en;
  logic                    clr;
  logic [CountBits-1:0]    result;

  logic                    out_valid_q;
  logic [IdxBits-1:0]      out_winner_q;
  logic [CountBits-1:0]    out_count_q;

  // cell address of the job at the queue head
  assign in_range = (job_i.row < IdxBits'(NumCenters)) && (job_i.col < IdxBits'(NumCenters));
  assign addr     = in_range
                  ? CellAddrBits'(CellAddrBits'(job_i.row) * CellAddrBits'(NumCenters)
                                  + CellAddrBits'(job_i.col))
                  : '0;

  // handshake between the update stage and the result register
  assign r_fire    = r_valid_q && (!out_valid_q || out_ready_i);
  assign pop       = job_valid_i && (!r_valid_q || r_fire);
  assign job_pop_o = pop;

  // current cell value, taking the write or clear of the job just ahead
  always_comb begin
    if (r_cleared_q) begin
      cur = '0;
    end else if (r_fwd_q) begin
      cur = r_fwd_data_q;
    end else if (rvalid_q) begin
      cur = rdata_q;
    end else begin
      cur = '0;
    end
    inc  = (cur == '1) ? cur : cur + 1'b1;
    w_en = r_fire && (r_job_q.req == REQ_CLASSIFY) && r_inrange_q;
    clr  = r_fire && (r_job_q.req == REQ_CLEAR);
    case (r_job_q.req)
      REQ_CLASSIFY: result = r_inrange_q ? inc : '0;
      REQ_READ:     result = r_inrange_q ? cur : '0;
      default:      result = '0;
    endcase
  end

  // matrix memory, registered read
  always_ff @(posedge clk_i) begin
    if (w_en) begin
      cell_mem[r_addr_q] <= inc;
    end
    if (pop) begin
      rdata_q <= cell_mem[addr];
    end
  end

  // written flags per cell, a clear drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= '0;
      rvalid_q     <= 1'b0;
    end else begin
      if (clr) begin
        cell_valid_q <= '0;
      end else if (w_en) begin
        cell_valid_q[r_addr_q] <= 1'b1;
      end
      if (pop) begin
        rvalid_q <= cell_valid_q[addr];
      end
    end
  end

  // update stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (pop) begin
      r_valid_q <= 1'b1;
    end else if (r_fire) begin
      r_valid_q <= 1'b0;
    end
  end

  // update stage payload with forwarding from the job leaving it
  always_ff @(posedge clk_i) begin
    if (pop) begin
      r_job_q      <= job_i;
      r_addr_q     <= addr;
      r_inrange_q  <= in_range;
      r_fwd_q      <= w_en && (r_addr_q == addr);
      r_fwd_data_q <= inc;
      r_cleared_q  <= clr;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (r_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_fire) begin
      out_winner_q <= r_job_q.winner;
      out_count_q  <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign winner_o     = out_winner_q;
  assign cell_count_o = out_count_q;

endmodule

// ===== rtl/nearest_centroid_confusion_counter.sv =====
// top level of the nearest centre classifier with confusion matrix
// depends on ncc_pkg, ncc_front, ncc_queue, ncc_back and the defines header
//
// channel  dir  handshake                 payload
// cfg      in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_wdata_i
// in       in   in_valid_i/in_ready_o     req_type_i, sample_*_i, true_class_i,
//                                         read_row_i, read_column_i
// out      out  out_valid_o/out_ready_i   winner_o, cell_count_o
//
// one transfer per cycle sustained while out_ready_i is high; from input transfer
// to result transfer each request passes five search stages, the job queue, one
// matrix update stage and the result register. credits cap the requests between
// input transfer and the back end at eight, the job queue depth. after reset every
// matrix cell reads zero at once through per-cell flags, with no clearing pass.
// a stalled output stops job pops, and in_ready_o drops once the credits run out.
`timescale 1ns / 1ps
`include "nearest_centroid_confusion_counter_defines.svh"

module nearest_centroid_confusion_counter import ncc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CenterBits-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic [SampleBits-1:0] sample_x_i,
  input  logic [SampleBits-1:0] sample_y_i,
  input  logic [SampleBits-1:0] sample_z_i,
  input  logic [IdxBits-1:0]    true_class_i,
  input  logic [IdxBits-1:0]    read_row_i,
  input  logic [IdxBits-1:0]    read_column_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IdxBits-1:0]    winner_o,
  output logic [CountBits-1:0]  cell_count_o
);

  logic                  in_accept;
  logic                  job_push;
  job_t                  push_job;
  job_t                  head_job;
  logic                  job_pop;
  q_status_t             q_status;
  logic [CreditBits-1:0] credit_q;

  // requests in flight, counted from input transfer until the back end takes them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      case ({in_accept, job_pop})
        2'b10:   credit_q <= credit_q + 1'b1;
        2'b01:   credit_q <= credit_q - 1'b1;
        default: credit_q <= credit_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (credit_q < CreditBits'(QueueDepth));
  assign in_accept   = in_valid_i && in_ready_o;

  ncc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (in_accept),
    .req_type_i    (req_type_i),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .sample_z_i    (sample_z_i),
    .true_class_i  (true_class_i),
    .read_row_i    (read_row_i),
    .read_column_i (read_column_i),
    .job_valid_o   (job_push),
    .job_o         (push_job)
  );

  ncc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (push_job),
    .pop_i       (job_pop),
    .data_o      (head_job),
    .status_o    (q_status)
  );

  ncc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!q_status.empty),
    .job_i        (head_job),
    .job_pop_o    (job_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .winner_o     (winner_o),
    .cell_count_o (cell_count_o)
  );

  // in-flight count never passes the queue size
  `NCC_ASSERT(a_credit_bound, 1'b1, credit_q <= CreditBits'(QueueDepth), "credit overrun")
  // the search pipeline never pushes into a full queue
  `NCC_ASSERT(a_no_overflow, job_push, !q_status.full || job_pop, "job queue overflow")
  // a delivered winner is always a real centre
  `NCC_ASSERT(a_winner_range, out_valid_o, winner_o < IdxBits'(NumCenters), "winner out of range")
  // an accepted request is still counted in the next cycle
  `NCC_ASSERT_NXT(a_credit_held, in_accept, credit_q != '0, "accepted request lost")

endmodule
